FILE: rtl/mtt_pkg.sv
// Package for the multitape transition table lookup block.
// Holds default sizes, command and status codes and the scan token type.
// Used by the interfaces, the table cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int TAPES_DEF       = 2;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int STATE_W = 8;
  localparam int SYM_W   = 16;
  localparam int MOVE_W  = 4;
  localparam int STAT_W  = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // A lookup key travelling down the row of cells, with the result it has
  // picked up so far.
  typedef struct packed {
    logic               vld;
    logic [STATE_W-1:0] st;
    logic [SYM_W-1:0]   rd;
    logic               hit;
    logic [STATE_W-1:0] nxt;
    logic [SYM_W-1:0]   wr;
    logic [MOVE_W-1:0]  mv;
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/mtt_if.sv
// Handshake interfaces for the request and result channels.
// Depends on mtt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mtt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [mtt_pkg::STATE_W-1:0] cur_state;
  logic [mtt_pkg::SYM_W-1:0]   read_symbols;
  logic [mtt_pkg::STATE_W-1:0] new_state;
  logic [mtt_pkg::SYM_W-1:0]   write_symbols;
  logic [mtt_pkg::MOVE_W-1:0]  moves;

  modport source (output valid, cmd, cur_state, read_symbols, new_state,
                  write_symbols, moves, input ready);
  modport sink (input valid, cmd, cur_state, read_symbols, new_state,
                write_symbols, moves, output ready);
endinterface

interface mtt_out_if;
  logic                        valid;
  logic                        ready;
  logic [mtt_pkg::STAT_W-1:0]  status;
  logic [mtt_pkg::STATE_W-1:0] next_state_out;
  logic [mtt_pkg::SYM_W-1:0]   write_out;
  logic [mtt_pkg::MOVE_W-1:0]  moves_out;

  modport source (output valid, status, next_state_out, write_out, moves_out,
                  input ready);
  modport sink (input valid, status, next_state_out, write_out, moves_out,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/multitape_transition_table_lookup.sv
// Top level of the multitape transition table lookup block.
// Depends on mtt_pkg, the mtt_in_if and mtt_out_if interfaces and mtt_cell.
//
// Entries are held in a row of ENTRIES cells, one entry per cell. An insert
// item writes the cell at the current fill count; its status is offered in
// the cycle after acceptance and can be taken at the next clock edge. A lookup
// item sends its key down the row, one cell per cycle, and the first held
// entry that matches supplies the result, which is registered from the end
// of the row before it is offered. One item is handled at a time, and the
// next is taken in the cycle after the result has been accepted. After reset
// the table is empty.
`timescale 1ns / 1ps
`default_nettype none

module multitape_transition_table_lookup #(
  parameter int ENTRIES     = mtt_pkg::ENTRIES_DEF,
  parameter int TAPES       = mtt_pkg::TAPES_DEF,
  parameter int SYMBOL_BITS = mtt_pkg::SYMBOL_BITS_DEF
) (
  input wire          clk,
  input wire          rst_n,
  mtt_in_if.sink      in_ch,
  mtt_out_if.source   out_ch
);

  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SYM_USED = (TAPES * SYMBOL_BITS > mtt_pkg::SYM_W) ?
                            mtt_pkg::SYM_W : TAPES * SYMBOL_BITS;
  localparam int MV_USED  = (2 * TAPES > mtt_pkg::MOVE_W) ?
                            mtt_pkg::MOVE_W : 2 * TAPES;
  localparam logic [mtt_pkg::SYM_W-1:0] SYM_MASK =
    mtt_pkg::SYM_W'((33'd1 << SYM_USED) - 33'd1);
  localparam logic [mtt_pkg::MOVE_W-1:0] MV_MASK =
    mtt_pkg::MOVE_W'((33'd1 << MV_USED) - 33'd1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  state_t                      state_r;
  logic [CNT_W-1:0]            count_r;
  mtt_pkg::token_t             launch_r;
  logic [mtt_pkg::STAT_W-1:0]  status_r;
  logic [mtt_pkg::STATE_W-1:0] nxt_out_r;
  logic [mtt_pkg::SYM_W-1:0]   wr_out_r;
  logic [mtt_pkg::MOVE_W-1:0]  mv_out_r;

  logic                        in_acc;
  logic                        wr_en;
  logic [mtt_pkg::SYM_W-1:0]   rd_masked;
  mtt_pkg::token_t             tok [0:ENTRIES];
  mtt_pkg::token_t             tail;

  assign in_acc    = in_ch.valid && (state_r == S_IDLE);
  assign wr_en     = in_acc && (in_ch.cmd == mtt_pkg::CMD_INSERT) &&
                     (count_r < FULL_CNT);
  assign rd_masked = in_ch.read_symbols & SYM_MASK;

  assign tok[0] = launch_r;
  assign tail   = tok[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mtt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_idx  (count_r),
      .wr_st   (in_ch.cur_state),
      .wr_rd   (rd_masked),
      .wr_nxt  (in_ch.new_state),
      .wr_wr   (in_ch.write_symbols & SYM_MASK),
      .wr_mv   (in_ch.moves & MV_MASK),
      .count   (count_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      launch_r     <= '0;
      status_r     <= mtt_pkg::STAT_OK;
      nxt_out_r    <= '0;
      wr_out_r     <= '0;
      mv_out_r     <= '0;
    end else begin
      launch_r.vld <= in_acc && (in_ch.cmd == mtt_pkg::CMD_LOOKUP);
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.cmd == mtt_pkg::CMD_INSERT) begin
              nxt_out_r <= '0;
              wr_out_r  <= '0;
              mv_out_r  <= '0;
              if (count_r < FULL_CNT) begin
                status_r <= mtt_pkg::STAT_OK;
                count_r  <= count_r + CNT_W'(1);
              end else begin
                status_r <= mtt_pkg::STAT_FULL;
              end
              state_r <= S_OUT;
            end else begin
              launch_r.st  <= in_ch.cur_state;
              launch_r.rd  <= rd_masked;
              launch_r.hit <= 1'b0;
              launch_r.nxt <= '0;
              launch_r.wr  <= '0;
              launch_r.mv  <= '0;
              state_r      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tail.vld) begin
            if (tail.hit) begin
              status_r  <= mtt_pkg::STAT_OK;
              nxt_out_r <= tail.nxt;
              wr_out_r  <= tail.wr;
              mv_out_r  <= tail.mv;
            end else begin
              status_r  <= mtt_pkg::STAT_NOMATCH;
              nxt_out_r <= '0;
              wr_out_r  <= '0;
              mv_out_r  <= '0;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = (state_r == S_OUT);
  assign out_ch.status         = status_r;
  assign out_ch.next_state_out = nxt_out_r;
  assign out_ch.write_out      = wr_out_r;
  assign out_ch.moves_out      = mv_out_r;

endmodule

`default_nettype wire

FILE: rtl/mtt_cell.sv
// One table cell: holds a single transition entry and compares the passing
// lookup token against it. Depends on mtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire [CNT_W-1:0]              wr_idx,
  input  wire [mtt_pkg::STATE_W-1:0]   wr_st,
  input  wire [mtt_pkg::SYM_W-1:0]     wr_rd,
  input  wire [mtt_pkg::STATE_W-1:0]   wr_nxt,
  input  wire [mtt_pkg::SYM_W-1:0]     wr_wr,
  input  wire [mtt_pkg::MOVE_W-1:0]    wr_mv,
  input  wire [CNT_W-1:0]              count,
  input  wire mtt_pkg::token_t         tok_in,
  output mtt_pkg::token_t              tok_out
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [mtt_pkg::STATE_W-1:0] st_r;
  logic [mtt_pkg::SYM_W-1:0]   rd_r;
  logic [mtt_pkg::STATE_W-1:0] nxt_r;
  logic [mtt_pkg::SYM_W-1:0]   wr_r;
  logic [mtt_pkg::MOVE_W-1:0]  mv_r;
  mtt_pkg::token_t             tok_r;
  mtt_pkg::token_t             tok_nxt;
  logic                        held;

  assign held = (count > MY_IDX);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.hit && held && (tok_in.st == st_r) &&
        (tok_in.rd == rd_r)) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.nxt = nxt_r;
      tok_nxt.wr  = wr_r;
      tok_nxt.mv  = mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      st_r  <= wr_st;
      rd_r  <= wr_rd;
      nxt_r <= wr_nxt;
      wr_r  <= wr_wr;
      mv_r  <= wr_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= '0;
    end else begin
      tok_r     <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire
